/* hdl/ray_voxel_walker_3d_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the ray voxel walker
// Shared assertion forms, clocked on aclk, with and without reset gating.
// ----------------------------------------------------------------------------
`ifndef RAY_VOXEL_WALKER_3D_MACROS_SVH
`define RAY_VOXEL_WALKER_3D_MACROS_SVH

// same-cycle implication, gated by reset
`define RVW_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, gated by reset
`define RVW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// state that must follow a reset cycle
`define RVW_ASSERT_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rvw_pkg.sv */
// ----------------------------------------------------------------------------
// rvw_pkg
// Types, widths and helpers shared by the ray voxel walker modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rvw_pkg;

    localparam int COORD_W = 16;
    localparam int VSIZE_W = 11;
    localparam int ERR_W   = COORD_W + 2;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t sz;
        coord_t ex;
        coord_t dx_half;
        coord_t dy;
        coord_t dz;
        coord_t dx_m_dy;
        coord_t dx_m_dz;
        coord_t ox;
        coord_t oy;
        coord_t oz;
        logic   dir_x;
        logic   dir_y;
        logic   dir_z;
        logic   swap_xy;
        logic   swap_xz;
    } rvw_job_t;

    function automatic coord_t abs_diff(input coord_t a, input coord_t b);
        return (a > b) ? coord_t'(a - b) : coord_t'(b - a);
    endfunction

endpackage

`default_nettype wire

/* hdl/ray_voxel_walker_3d.sv */
// ----------------------------------------------------------------------------
// ray_voxel_walker_3d
// 3D Bresenham ray walker: emits the voxels a ray passes as free, then the
// end point as occupied.
//
//   Channel   Dir  Handshake           Contents
//   cfg       in   cfg_wr_en           voxel_size
//   s_        in   s_tvalid/s_tready   start_x/y/z, end_x/y/z
//   m_        out  m_tvalid/m_tready   voxel_x/y/z, occupied (tuser), last (tlast)
//
// A ray with k free voxels occupies the walker from loading its job until
// the occupied end point is emitted; k is at most 2^GRID_DEPTH-1, set by
// the single-step walk loop, and no new job is taken in the meantime.
// Axis selection is registered (front stages a, b) ahead of a two-job queue.
// Reset is synchronous; voxel_size returns to 1 and the job queue empties.
// Either side may stall at any time; the queue decouples the two halves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ray_voxel_walker_3d import rvw_pkg::*; #(
    parameter int GRID_DEPTH = 6
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [VSIZE_W-1:0] cfg_wr_data,   // voxel_size
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z
    input  wire logic [6*COORD_W-1:0] s_tdata,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [3*COORD_W-1:0]    m_tdata,       // voxel_x, voxel_y, voxel_z
    output logic                    m_tuser,       // occupied
    output logic                    m_tlast
);

    logic [VSIZE_W-1:0] voxel_size_reg;

    logic     f_valid, f_ready, q_valid, q_ready;
    rvw_job_t f_job, q_job;
    coord_t   vx, vy, vz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            voxel_size_reg <= VSIZE_W'(1);
        end else if (cfg_wr_en) begin
            voxel_size_reg <= cfg_wr_data;
        end
    end

    rvw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .start_x   (s_tdata[COORD_W-1:0]),
        .start_y   (s_tdata[2*COORD_W-1:COORD_W]),
        .start_z   (s_tdata[3*COORD_W-1:2*COORD_W]),
        .end_x     (s_tdata[4*COORD_W-1:3*COORD_W]),
        .end_y     (s_tdata[5*COORD_W-1:4*COORD_W]),
        .end_z     (s_tdata[6*COORD_W-1:5*COORD_W]),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    rvw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_job    (q_job)
    );

    rvw_back #(
        .GRID_DEPTH (GRID_DEPTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .voxel_size (voxel_size_reg),
        .job_valid  (q_valid),
        .job_ready  (q_ready),
        .job        (q_job),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .voxel_x    (vx),
        .voxel_y    (vy),
        .voxel_z    (vz),
        .occupied   (m_tuser),
        .last       (m_tlast)
    );

    assign m_tdata = {vz, vy, vx};

endmodule

`default_nettype wire

/* hdl/rvw_front.sv */
// ----------------------------------------------------------------------------
// rvw_front
// Accepts rays, picks the driving axis in two registered stages and emits a
// walk job with deltas, directions and error increments.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rvw_front import rvw_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire coord_t   start_x,
    input  wire coord_t   start_y,
    input  wire coord_t   start_z,
    input  wire coord_t   end_x,
    input  wire coord_t   end_y,
    input  wire coord_t   end_z,
    output logic          job_valid,
    input  wire logic     job_ready,
    output rvw_job_t      job
);

    logic   a_valid_reg;
    coord_t a_sx_reg, a_sy_reg, a_sz_reg, a_ex_reg, a_ey_reg, a_ez_reg;

    logic   b_valid_reg;
    logic   b_swap_xy_reg;
    coord_t b_sx_reg, b_sy_reg, b_sz_reg, b_ex_reg, b_ey_reg, b_ez_reg;
    coord_t b_ox_reg, b_oy_reg, b_oz_reg;

    logic   a_ready, b_ready;
    coord_t a_dx, a_dy;
    logic   a_swap_xy;

    coord_t b_dx1, b_dz1, f_sx, f_sz, f_ex, f_ez, f_dx, f_dy, f_dz;
    logic   b_swap_xz;

    assign b_ready  = !b_valid_reg || job_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    assign a_dx      = abs_diff(a_ex_reg, a_sx_reg);
    assign a_dy      = abs_diff(a_ey_reg, a_sy_reg);
    assign a_swap_xy = a_dy > a_dx;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_sx_reg <= start_x;
            a_sy_reg <= start_y;
            a_sz_reg <= start_z;
            a_ex_reg <= end_x;
            a_ey_reg <= end_y;
            a_ez_reg <= end_z;
        end
        if (b_ready && a_valid_reg) begin
            b_swap_xy_reg <= a_swap_xy;
            b_sx_reg      <= a_swap_xy ? a_sy_reg : a_sx_reg;
            b_sy_reg      <= a_swap_xy ? a_sx_reg : a_sy_reg;
            b_ex_reg      <= a_swap_xy ? a_ey_reg : a_ex_reg;
            b_ey_reg      <= a_swap_xy ? a_ex_reg : a_ey_reg;
            b_sz_reg      <= a_sz_reg;
            b_ez_reg      <= a_ez_reg;
            b_ox_reg      <= a_ex_reg;
            b_oy_reg      <= a_ey_reg;
            b_oz_reg      <= a_ez_reg;
        end
    end

    assign b_dx1     = abs_diff(b_ex_reg, b_sx_reg);
    assign b_dz1     = abs_diff(b_ez_reg, b_sz_reg);
    assign b_swap_xz = b_dz1 > b_dx1;
    assign f_sx      = b_swap_xz ? b_sz_reg : b_sx_reg;
    assign f_sz      = b_swap_xz ? b_sx_reg : b_sz_reg;
    assign f_ex      = b_swap_xz ? b_ez_reg : b_ex_reg;
    assign f_ez      = b_swap_xz ? b_ex_reg : b_ez_reg;
    assign f_dx      = b_swap_xz ? b_dz1 : b_dx1;
    assign f_dz      = b_swap_xz ? b_dx1 : b_dz1;
    assign f_dy      = abs_diff(b_ey_reg, b_sy_reg);

    always_comb begin
        job.sx      = f_sx;
        job.sy      = b_sy_reg;
        job.sz      = f_sz;
        job.ex      = f_ex;
        job.dx_half = f_dx >> 1;
        job.dy      = f_dy;
        job.dz      = f_dz;
        job.dx_m_dy = f_dx - f_dy;
        job.dx_m_dz = f_dx - f_dz;
        job.ox      = b_ox_reg;
        job.oy      = b_oy_reg;
        job.oz      = b_oz_reg;
        job.dir_x   = f_sx < f_ex;
        job.dir_y   = b_sy_reg < b_ey_reg;
        job.dir_z   = f_sz < f_ez;
        job.swap_xy = b_swap_xy_reg;
        job.swap_xz = b_swap_xz;
    end

    assign job_valid = b_valid_reg;

endmodule

`default_nettype wire

/* hdl/rvw_queue.sv */
// ----------------------------------------------------------------------------
// rvw_queue
// Two-entry job queue between the ray front end and the walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rvw_queue import rvw_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push_valid,
    output logic          push_ready,
    input  wire rvw_job_t push_job,
    output logic          pop_valid,
    input  wire logic     pop_ready,
    output rvw_job_t      pop_job
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    rvw_job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_job    = slot_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

/* hdl/rvw_back.sv */
// ----------------------------------------------------------------------------
// rvw_back
// Walks one job with Bresenham stepping, one voxel per cycle unless stalled,
// into a registered output stage; ends each ray with the occupied end voxel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rvw_back import rvw_pkg::*; #(
    parameter int GRID_DEPTH = 6
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic [VSIZE_W-1:0] voxel_size,
    input  wire logic               job_valid,
    output logic                    job_ready,
    input  wire rvw_job_t           job,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output coord_t                  voxel_x,
    output coord_t                  voxel_y,
    output coord_t                  voxel_z,
    output logic                    occupied,
    output logic                    last
);

    logic                         active_reg;
    logic                         out_valid_reg;
    rvw_job_t                     job_reg;
    coord_t                       x_reg, y_reg, z_reg;
    logic signed [ERR_W-1:0]      err_xy_reg, err_xz_reg;
    logic [GRID_DEPTH-1:0]        n_reg;
    coord_t                       out_x_reg, out_y_reg, out_z_reg;
    logic                         out_occ_reg, out_last_reg;

    logic                         load, emit, out_free, step_ok;
    coord_t                       vs, x_next, y_next, z_next;
    coord_t                       px0, pz0, px, py, pz;
    logic signed [ERR_W-1:0]      err_xy_sub, err_xz_sub, err_xy_next, err_xz_next;

    assign vs        = COORD_W'(voxel_size);
    assign out_free  = !out_valid_reg || out_ready;
    assign job_ready = !active_reg;
    assign load      = job_valid && !active_reg;
    assign emit      = active_reg && out_free;
    assign step_ok   = !(&n_reg) && (abs_diff(x_reg, job_reg.ex) > vs);

    assign err_xy_sub  = err_xy_reg - $signed({2'b00, job_reg.dy});
    assign err_xz_sub  = err_xz_reg - $signed({2'b00, job_reg.dz});
    assign err_xy_next = err_xy_sub[ERR_W-1] ? (err_xy_reg + $signed({2'b00, job_reg.dx_m_dy}))
                                             : err_xy_sub;
    assign err_xz_next = err_xz_sub[ERR_W-1] ? (err_xz_reg + $signed({2'b00, job_reg.dx_m_dz}))
                                             : err_xz_sub;

    assign x_next = job_reg.dir_x ? coord_t'(x_reg + vs) : coord_t'(x_reg - vs);
    assign y_next = !err_xy_sub[ERR_W-1] ? y_reg :
                    job_reg.dir_y ? coord_t'(y_reg + vs) : coord_t'(y_reg - vs);
    assign z_next = !err_xz_sub[ERR_W-1] ? z_reg :
                    job_reg.dir_z ? coord_t'(z_reg + vs) : coord_t'(z_reg - vs);

    // undo the axis swaps, last swap first
    assign px0 = job_reg.swap_xz ? z_reg : x_reg;
    assign pz0 = job_reg.swap_xz ? x_reg : z_reg;
    assign px  = job_reg.swap_xy ? y_reg : px0;
    assign py  = job_reg.swap_xy ? px0 : y_reg;
    assign pz  = pz0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                active_reg <= 1'b1;
            end else if (emit && !step_ok) begin
                active_reg <= 1'b0;
            end
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg    <= job;
            x_reg      <= job.sx;
            y_reg      <= job.sy;
            z_reg      <= job.sz;
            err_xy_reg <= $signed({2'b00, job.dx_half});
            err_xz_reg <= $signed({2'b00, job.dx_half});
            n_reg      <= '0;
        end else if (emit) begin
            if (step_ok) begin
                out_x_reg    <= px;
                out_y_reg    <= py;
                out_z_reg    <= pz;
                out_occ_reg  <= 1'b0;
                out_last_reg <= 1'b0;
                x_reg        <= x_next;
                y_reg        <= y_next;
                z_reg        <= z_next;
                err_xy_reg   <= err_xy_next;
                err_xz_reg   <= err_xz_next;
                n_reg        <= n_reg + 1'b1;
            end else begin
                out_x_reg    <= job_reg.ox;
                out_y_reg    <= job_reg.oy;
                out_z_reg    <= job_reg.oz;
                out_occ_reg  <= 1'b1;
                out_last_reg <= 1'b1;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign voxel_x   = out_x_reg;
    assign voxel_y   = out_y_reg;
    assign voxel_z   = out_z_reg;
    assign occupied  = out_occ_reg;
    assign last      = out_last_reg;

endmodule

`default_nettype wire

/* hdl/rvw_checker.sv */
// ----------------------------------------------------------------------------
// rvw_checker
// Port-level checks on the result stream of the ray voxel walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ray_voxel_walker_3d_macros.svh"

module rvw_checker import rvw_pkg::*; #(
    parameter int GRID_DEPTH = 6
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [3*COORD_W-1:0] m_tdata,
    input  wire logic                 m_tuser,
    input  wire logic                 m_tlast
);

    logic [GRID_DEPTH-1:0] free_cnt_reg;
    logic                  m_stall;

    assign m_stall = m_tvalid && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_cnt_reg <= '0;
        end else if (m_tvalid && m_tready) begin
            free_cnt_reg <= m_tlast ? '0 : free_cnt_reg + 1'b1;
        end
    end

    `RVW_ASSERT_IMPLY(a_occ_on_last, m_tvalid, m_tuser == m_tlast, "occupied differs from last")
    `RVW_ASSERT_IMPLY(a_free_limit, m_tvalid && !m_tlast, !(&free_cnt_reg), "too many free voxels")
    `RVW_ASSERT_NEXT(a_hold, m_stall, m_tvalid && $stable({m_tdata, m_tlast}), "held data moved")
    `RVW_ASSERT_RESET(a_reset_idle, !m_tvalid, "result valid after reset")

endmodule

bind ray_voxel_walker_3d rvw_checker #(
    .GRID_DEPTH (GRID_DEPTH)
) u_rvw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
